[src/pps_pkg.sv]
// Shared types and codes for the preemptive priority scheduler.
`default_nettype none
package pps_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned BurstW = 16;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned StatW  = 3;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 88;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic [StatW-1:0] {
    ST_INSERTED   = 3'd0,
    ST_FULL       = 3'd1,
    ST_ZERO_BURST = 3'd2,
    ST_RAN        = 3'd3,
    ST_IDLE       = 3'd4
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [IdW-1:0]    id;
    logic [PrioW-1:0]  prio;
    logic [TimeW-1:0]  arrival;
    logic [BurstW-1:0] burst;
    logic [BurstW-1:0] remaining;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
    logic dec;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[src/pps_cell.sv]
// One slot of the sorted job chain: hold, take new job, shift right or left, decrement.
`default_nettype none
module pps_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pps_pkg::cell_ctrl_t ctrl_i,
  input  wire pps_pkg::entry_t    new_i,
  input  wire pps_pkg::entry_t    left_i,
  input  wire logic               left_keep_i,
  input  wire pps_pkg::entry_t    right_i,
  output pps_pkg::entry_t         cur_o,
  output logic                    keep_o
);

  pps_pkg::entry_t entry_r;
  pps_pkg::entry_t entry_nxt;

  assign cur_o  = entry_r;
  assign keep_o = entry_r.valid && (entry_r.prio <= new_i.prio);

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl_i.insert) begin
      if (!keep_o) begin
        entry_nxt = left_keep_i ? new_i : left_i;
      end
    end else if (ctrl_i.pop) begin
      entry_nxt = right_i;
    end else if (ctrl_i.dec) begin
      entry_nxt.remaining = entry_r.remaining - pps_pkg::BurstW'(1);
    end
  end

  always_ff @(posedge clk) begin
    entry_r.id        <= entry_nxt.id;
    entry_r.prio      <= entry_nxt.prio;
    entry_r.arrival   <= entry_nxt.arrival;
    entry_r.burst     <= entry_nxt.burst;
    entry_r.remaining <= entry_nxt.remaining;
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
  end

endmodule
`default_nettype wire

[src/preemptive_priority_scheduler.sv]
// Top level: command decode, tick counter, sorted cell chain and result register.
//
//  channel | direction | tdata                                   | tuser
//  in_     | slave     | job_id, burst_len, job_priority         | cmd
//  out_    | master    | ran_id, finished, wait_time, turnaround | status
//
// One item per cycle while results are taken: the chain is kept sorted by
// priority, then insertion order, so the head cell always holds the job to serve.
// An insert shifts later cells right; a finished job shifts the chain
// left. The result is registered and appears in the cycle after accept.
// Reset empties every cell and clears the tick counter and output valid.
// A result not taken stalls the input until the output register frees.
`default_nettype none
module preemptive_priority_scheduler #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // job_id[15:0], burst_len[31:16], job_priority[39:32]
  input  wire logic        in_tuser,  // cmd[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata, // ran_id[15:0], finished[16], wait_time[48:17],
                                      // turnaround[80:49], zero[87:81]
  output logic [2:0]       out_tuser  // status[2:0]
);

  pps_pkg::entry_t    cur   [ENTRIES];
  logic [ENTRIES-1:0] keep;
  logic [ENTRIES-1:0] cell_valid;
  pps_pkg::entry_t    new_entry;
  pps_pkg::entry_t    empty_entry;
  pps_pkg::cell_ctrl_t ctrl;
  pps_pkg::cell_ctrl_t head_ctrl;
  pps_pkg::cell_ctrl_t tail_ctrl;

  logic [pps_pkg::TimeW-1:0] tick_r;
  logic [pps_pkg::TimeW-1:0] tick_nxt;
  logic                      out_valid_r;
  logic [pps_pkg::IdW-1:0]   ran_id_r;
  logic                      finished_r;
  logic [pps_pkg::TimeW-1:0] wait_r;
  logic [pps_pkg::TimeW-1:0] tat_r;
  pps_pkg::status_t          status_r;

  pps_pkg::status_t          status_c;
  logic [pps_pkg::IdW-1:0]   ran_id_c;
  logic                      finished_c;
  logic [pps_pkg::TimeW-1:0] wait_c;
  logic [pps_pkg::TimeW-1:0] tat_c;
  logic [pps_pkg::TimeW-1:0] finish_t;

  logic in_acc;
  logic out_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;

  assign new_entry.valid     = 1'b1;
  assign new_entry.id        = in_tdata[15:0];
  assign new_entry.burst     = in_tdata[31:16];
  assign new_entry.remaining = in_tdata[31:16];
  assign new_entry.prio      = in_tdata[39:32];
  assign new_entry.arrival   = tick_r;
  assign empty_entry         = '0;

  assign finish_t = tick_r + pps_pkg::TimeW'(1);

  always_comb begin
    ctrl       = '0;
    status_c   = pps_pkg::ST_IDLE;
    ran_id_c   = '0;
    finished_c = 1'b0;
    wait_c     = '0;
    tat_c      = '0;
    tick_nxt   = tick_r;
    if (in_acc) begin
      unique case (pps_pkg::cmd_t'(in_tuser))
        pps_pkg::CMD_INSERT: begin
          priority if (in_tdata[31:16] == '0) begin
            status_c = pps_pkg::ST_ZERO_BURST;
          end else if (cell_valid[ENTRIES-1]) begin
            status_c = pps_pkg::ST_FULL;
          end else begin
            status_c    = pps_pkg::ST_INSERTED;
            ctrl.insert = 1'b1;
          end
        end
        pps_pkg::CMD_TICK: begin
          tick_nxt = finish_t;
          if (cur[0].valid) begin
            status_c = pps_pkg::ST_RAN;
            ran_id_c = cur[0].id;
            if (cur[0].remaining <= pps_pkg::BurstW'(1)) begin
              finished_c = 1'b1;
              ctrl.pop   = 1'b1;
              tat_c      = finish_t - cur[0].arrival;
              wait_c     = tat_c - pps_pkg::TimeW'(cur[0].burst);
            end else begin
              ctrl.dec = 1'b1;
            end
          end
        end
        default: status_c = pps_pkg::ST_IDLE;
      endcase
    end
  end

  assign head_ctrl = ctrl;
  assign tail_ctrl = '{insert: ctrl.insert, pop: ctrl.pop, dec: 1'b0};

  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
    pps_pkg::entry_t left_e;
    pps_pkg::entry_t right_e;
    logic            left_k;
    if (gi == 0) begin : g_first
      assign left_e = new_entry;
      assign left_k = 1'b1;
    end else begin : g_mid
      assign left_e = cur[gi-1];
      assign left_k = keep[gi-1];
    end
    if (gi == ENTRIES - 1) begin : g_last
      assign right_e = empty_entry;
    end else begin : g_inner
      assign right_e = cur[gi+1];
    end
    pps_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl_i      ((gi == 0) ? head_ctrl : tail_ctrl),
      .new_i       (new_entry),
      .left_i      (left_e),
      .left_keep_i (left_k),
      .right_i     (right_e),
      .cur_o       (cur[gi]),
      .keep_o      (keep[gi])
    );
    assign cell_valid[gi] = cur[gi].valid;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r   <= status_c;
      ran_id_r   <= ran_id_c;
      finished_r <= finished_c;
      wait_r     <= wait_c;
      tat_r      <= tat_c;
    end
    if (!rst_n) begin
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tick_r <= tick_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {7'd0, tat_r, wait_r, finished_r, ran_id_r};

  a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + 1'b1) & cell_valid) == '0)
    else $error("job chain has a gap");

  a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
    cur[0].valid |-> (cur[0].remaining != '0))
    else $error("head job has no service left");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.insert |=> ($countones(cell_valid) == $past($countones(cell_valid)) + 1))
    else $error("insert did not add a job");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |=> ($countones(cell_valid) + 1 == $past($countones(cell_valid))))
    else $error("finished job not removed");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_acc)
    else $error("item taken while result waits");

endmodule
`default_nettype wire

[verif/preemptive_priority_scheduler_tb.sv]
// Self-checking testbench for the preemptive priority scheduler: directed and random jobs.
module preemptive_priority_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned REPORT_CAP = 50;

  typedef struct packed {
    pps_pkg::status_t status;
    logic [15:0]      ran_id;
    logic             finished;
    logic [31:0]      wait_time;
    logic [31:0]      turnaround;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [39:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [87:0] out_tdata;
  logic [2:0] out_tuser;

  logic slot_valid [ENTRIES];
  logic [15:0] slot_id [ENTRIES];
  logic [7:0] slot_prio [ENTRIES];
  logic [31:0] slot_arrival [ENTRIES];
  logic [15:0] slot_burst [ENTRIES];
  logic [15:0] slot_left [ENTRIES];
  logic [31:0] slot_seq [ENTRIES];
  logic [31:0] now_tick;
  logic [31:0] seq_cnt;
  int jobs_held;

  sched_result_t pending_results [$];
  sched_result_t got;
  sched_result_t want;

  int errors;
  int cycles;
  int hold_len;
  int sink_gap;
  bit src_gaps;
  bit sink_gaps;
  int n_insert;
  int n_tick;
  int n_done;
  int n_full;
  int n_idle;

  preemptive_priority_scheduler #(.ENTRIES(ENTRIES)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic sched_result_t schedule_step(input pps_pkg::cmd_t cmd,
                                                  input logic [15:0] id,
                                                  input logic [15:0] burst,
                                                  input logic [7:0] prio);
    sched_result_t r;
    int pick;
    int free_slot;
    logic [31:0] age;
    logic [31:0] pick_age;
    logic [31:0] tat;
    r = '0;
    pick = -1;
    free_slot = -1;
    pick_age = '0;
    if (cmd == pps_pkg::CMD_INSERT) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!slot_valid[i] && free_slot < 0) begin
          free_slot = i;
        end
      end
      if (burst == 16'd0) begin
        r.status = pps_pkg::ST_ZERO_BURST;
      end else if (free_slot < 0) begin
        r.status = pps_pkg::ST_FULL;
      end else begin
        slot_valid[free_slot] = 1'b1;
        slot_id[free_slot] = id;
        slot_prio[free_slot] = prio;
        slot_arrival[free_slot] = now_tick;
        slot_burst[free_slot] = burst;
        slot_left[free_slot] = burst;
        slot_seq[free_slot] = seq_cnt;
        seq_cnt = seq_cnt + 32'd1;
        jobs_held++;
        r.status = pps_pkg::ST_INSERTED;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i]) begin
          age = seq_cnt - slot_seq[i];
          if (pick < 0 || slot_prio[i] < slot_prio[pick] ||
              (slot_prio[i] == slot_prio[pick] && age > pick_age)) begin
            pick = i;
            pick_age = age;
          end
        end
      end
      if (pick < 0) begin
        r.status = pps_pkg::ST_IDLE;
      end else begin
        r.status = pps_pkg::ST_RAN;
        r.ran_id = slot_id[pick];
        if (slot_left[pick] <= 16'd1) begin
          tat = now_tick + 32'd1 - slot_arrival[pick];
          r.finished = 1'b1;
          r.turnaround = tat;
          r.wait_time = tat - {16'd0, slot_burst[pick]};
          slot_left[pick] = 16'd0;
          slot_valid[pick] = 1'b0;
          jobs_held--;
        end else begin
          slot_left[pick] = slot_left[pick] - 16'd1;
        end
      end
      now_tick = now_tick + 32'd1;
    end
    return r;
  endfunction

  task automatic push_command(input pps_pkg::cmd_t cmd, input logic [15:0] id,
                              input logic [15:0] burst, input logic [7:0] prio);
    sched_result_t r;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {prio, burst, id};
    in_tuser <= cmd;
    do @(posedge clk); while (in_tready !== 1'b1);
    r = schedule_step(cmd, id, burst, prio);
    pending_results.push_back(r);
    if (cmd == pps_pkg::CMD_INSERT) n_insert++;
    else n_tick++;
    if (r.status == pps_pkg::ST_FULL) n_full++;
    if (r.status == pps_pkg::ST_IDLE) n_idle++;
    if (r.finished) n_done++;
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (errors < REPORT_CAP) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.status = pps_pkg::status_t'(out_tuser);
      got.ran_id = out_tdata[15:0];
      got.finished = out_tdata[16];
      got.wait_time = out_tdata[48:17];
      got.turnaround = out_tdata[80:49];
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected item, status", '0, {29'd0, out_tuser});
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) note_mismatch("status", want.status, got.status);
        if (got.ran_id != want.ran_id) note_mismatch("ran_id", want.ran_id, got.ran_id);
        if (got.finished != want.finished) note_mismatch("finished", want.finished, got.finished);
        if (got.wait_time != want.wait_time) begin
          note_mismatch("wait_time", want.wait_time, got.wait_time);
        end
        if (got.turnaround != want.turnaround) begin
          note_mismatch("turnaround", want.turnaround, got.turnaround);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d items outstanding", cycles, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    hold_len = 0;
    sink_gap = 0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        hold_len = hold_len - 1;
      end else if (sink_gap > 0) begin
        out_tready <= 1'b0;
        sink_gap = sink_gap - 1;
      end else if (sink_gaps && rst_n && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        sink_gap = $urandom_range(0, 7);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic test_empty_table();
    push_command(pps_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
    push_command(pps_pkg::CMD_INSERT, 16'h1234, 16'd0, 8'd3);
  endtask

  task automatic test_field_extremes();
    push_command(pps_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF);
    push_command(pps_pkg::CMD_INSERT, 16'h0000, 16'd1, 8'h00);
    push_command(pps_pkg::CMD_TICK, 16'h0000, 16'h0000, 8'h00);
    push_command(pps_pkg::CMD_INSERT, 16'h00A5, 16'd2, 8'd7);
    push_command(pps_pkg::CMD_INSERT, 16'h5A00, 16'd1, 8'd7);
    push_command(pps_pkg::CMD_TICK, 16'hAAAA, 16'h5555, 8'hA5);
    push_command(pps_pkg::CMD_TICK, 16'h5555, 16'hAAAA, 8'h5A);
    push_command(pps_pkg::CMD_TICK, 16'h0000, 16'h0000, 8'h00);
    push_command(pps_pkg::CMD_TICK, 16'h0000, 16'h0000, 8'h00);
  endtask

  task automatic test_preemption();
    push_command(pps_pkg::CMD_INSERT, 16'h0101, 16'd3, 8'd10);
    push_command(pps_pkg::CMD_TICK, 16'h0000, 16'h0000, 8'h00);
    push_command(pps_pkg::CMD_INSERT, 16'h0202, 16'd1, 8'd2);
    push_command(pps_pkg::CMD_TICK, 16'h0000, 16'h0000, 8'h00);
    push_command(pps_pkg::CMD_TICK, 16'h0000, 16'h0000, 8'h00);
  endtask

  task automatic test_full_table();
    while (jobs_held < ENTRIES) begin
      push_command(pps_pkg::CMD_INSERT, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(1, 3)), 8'($urandom_range(0, 15)));
    end
    push_command(pps_pkg::CMD_INSERT, 16'h7777, 16'd5, 8'd1);
    push_command(pps_pkg::CMD_INSERT, 16'h8888, 16'd0, 8'd1);
  endtask

  task automatic test_random_mix(input int count, input int insert_pct);
    int roll;
    logic [15:0] burst;
    logic [7:0] prio;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < insert_pct) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) burst = 16'd0;
        else if (roll < 10) burst = 16'($urandom_range(4, 200));
        else burst = 16'($urandom_range(1, 3));
        if ($urandom_range(0, 5) == 0) prio = 8'($urandom_range(0, 255));
        else prio = 8'($urandom_range(0, 7));
        push_command(pps_pkg::CMD_INSERT, 16'($urandom_range(0, 65535)), burst, prio);
      end else begin
        push_command(pps_pkg::CMD_TICK, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_backpressure();
    src_gaps = 1'b0;
    hold_len = 60;
    test_random_mix(30, 50);
    src_gaps = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = pps_pkg::CMD_INSERT;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    errors = 0;
    cycles = 0;
    jobs_held = 0;
    now_tick = '0;
    seq_cnt = '0;
    n_insert = 0;
    n_tick = 0;
    n_done = 0;
    n_full = 0;
    n_idle = 0;
    for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_field_extremes();
    test_preemption();
    test_full_table();
    test_random_mix(300, 40);
    test_backpressure();
    test_random_mix(150, 60);
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    test_random_mix(150, 30);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d inserts (%0d refused on a full table) and %0d ticks (%0d idle)",
             n_insert, n_full, n_tick, n_idle);
    $display("%0d jobs ran to completion, %0d still held, %0d mismatches",
             n_done, jobs_held, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
